[sv/sap_pkg.sv]
// ----------------------------------------------------------------------------
// sap_pkg
// Types and codes shared by the sensor advertisement object parser.
// ----------------------------------------------------------------------------
package sap_pkg;

  // parse phase codes
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_ID     = 3'd1;
  localparam logic [2:0] PH_VAL0   = 3'd2;
  localparam logic [2:0] PH_VAL1   = 3'd3;
  localparam logic [2:0] PH_HALT   = 3'd4;

  // object ids
  localparam logic [7:0] ID_PACKET      = 8'h00;
  localparam logic [7:0] ID_BATTERY     = 8'h01;
  localparam logic [7:0] ID_TEMP_CENTI  = 8'h02;
  localparam logic [7:0] ID_HUMID_CENTI = 8'h03;
  localparam logic [7:0] ID_VOLT        = 8'h0C;
  localparam logic [7:0] ID_HUMID_PCT   = 8'h2E;
  localparam logic [7:0] ID_TEMP_DECI   = 8'h45;

  // device info byte
  localparam logic [2:0] HDR_VERSION = 3'd2;

  // seen flag bit positions
  localparam int unsigned SEEN_PKT = 0;
  localparam int unsigned SEEN_BAT = 1;
  localparam int unsigned SEEN_TMP = 2;
  localparam int unsigned SEEN_HUM = 3;
  localparam int unsigned SEEN_VLT = 4;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } byte_beat_t;

  typedef struct packed {
    logic               frame_valid;
    logic               frame_complete;
    logic [7:0]         packet_number;
    logic               has_packet_number;
    logic [7:0]         battery_percent;
    logic               has_battery;
    logic signed [19:0] temp_centideg;
    logic               has_temp;
    logic [15:0]        humid_centipct;
    logic               has_humid;
    logic [15:0]        volt_millivolts;
    logic               has_volt;
  } result_beat_t;

  typedef struct packed {
    logic [2:0]         phase;
    logic [7:0]         pending_id;
    logic [7:0]         low_value_byte;
    logic [7:0]         packet_store;
    logic [7:0]         battery_store;
    logic signed [19:0] temp_store;
    logic [15:0]        humid_store;
    logic [15:0]        volt_store;
    logic [4:0]         seen_flags;
    logic               header_ok;
  } parse_state_t;

endpackage

[sv/sap_byte_if.sv]
// ----------------------------------------------------------------------------
// sap_byte_if
// Payload byte channel: one byte of the frame per beat.
// ----------------------------------------------------------------------------
interface sap_byte_if import sap_pkg::*;;

  logic       valid;
  logic       ready;
  byte_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

[sv/sap_result_if.sv]
// ----------------------------------------------------------------------------
// sap_result_if
// Result channel: one parsed frame summary per beat.
// ----------------------------------------------------------------------------
interface sap_result_if import sap_pkg::*;;

  logic         valid;
  logic         ready;
  result_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

[sv/sap_step.sv]
// ----------------------------------------------------------------------------
// sap_step
// Next parse state and frame summary for one payload byte.
// ----------------------------------------------------------------------------
module sap_step import sap_pkg::*; (
  input  parse_state_t state_i,
  input  byte_beat_t   beat_i,
  output parse_state_t state_o,
  output result_beat_t result_o
);

  function automatic logic [1:0] obj_len(input logic [7:0] id);
    logic [1:0] len;
    unique case (id)
      ID_PACKET, ID_BATTERY, ID_HUMID_PCT: len = 2'd1;
      ID_TEMP_CENTI, ID_HUMID_CENTI, ID_VOLT, ID_TEMP_DECI: len = 2'd2;
      default: len = 2'd0;
    endcase
    return len;
  endfunction

  parse_state_t       s;
  logic               apply_en;
  logic [15:0]        apply_val;
  logic signed [19:0] temp_x1;
  logic signed [19:0] temp_x10;
  logic [15:0]        humid_pct;

  assign temp_x1   = signed'({{4{apply_val[15]}}, apply_val});
  assign temp_x10  = (temp_x1 <<< 3) + (temp_x1 <<< 1);
  assign humid_pct = {8'd0, apply_val[7:0]} * 16'd100;

  always_comb begin
    s         = state_i;
    apply_en  = 1'b0;
    apply_val = {8'd0, beat_i.byte_value};

    unique case (state_i.phase)
      PH_HEADER: begin
        if (!beat_i.byte_value[0] && beat_i.byte_value[7:5] == HDR_VERSION) begin
          s.header_ok = 1'b1;
          s.phase     = PH_ID;
        end else begin
          s.header_ok = 1'b0;
          s.phase     = PH_HALT;
        end
      end
      PH_ID: begin
        if (obj_len(beat_i.byte_value) == 2'd0) begin
          s.phase = PH_HALT;
        end else begin
          s.pending_id = beat_i.byte_value;
          s.phase      = PH_VAL0;
        end
      end
      PH_VAL0: begin
        if (obj_len(state_i.pending_id) == 2'd1) begin
          apply_en = 1'b1;
          s.phase  = PH_ID;
        end else begin
          s.low_value_byte = beat_i.byte_value;
          s.phase          = PH_VAL1;
        end
      end
      PH_VAL1: begin
        apply_en  = 1'b1;
        apply_val = {beat_i.byte_value, state_i.low_value_byte};
        s.phase   = PH_ID;
      end
      default: ;
    endcase

    if (apply_en) begin
      unique case (state_i.pending_id)
        ID_PACKET: begin
          s.packet_store         = apply_val[7:0];
          s.seen_flags[SEEN_PKT] = 1'b1;
        end
        ID_BATTERY: begin
          s.battery_store        = apply_val[7:0];
          s.seen_flags[SEEN_BAT] = 1'b1;
        end
        ID_HUMID_PCT: begin
          if (!state_i.seen_flags[SEEN_HUM]) begin
            s.humid_store          = humid_pct;
            s.seen_flags[SEEN_HUM] = 1'b1;
          end
        end
        ID_HUMID_CENTI: begin
          if (!state_i.seen_flags[SEEN_HUM]) begin
            s.humid_store          = apply_val;
            s.seen_flags[SEEN_HUM] = 1'b1;
          end
        end
        ID_TEMP_CENTI: begin
          if (!state_i.seen_flags[SEEN_TMP]) begin
            s.temp_store           = temp_x1;
            s.seen_flags[SEEN_TMP] = 1'b1;
          end
        end
        ID_TEMP_DECI: begin
          if (!state_i.seen_flags[SEEN_TMP]) begin
            s.temp_store           = temp_x10;
            s.seen_flags[SEEN_TMP] = 1'b1;
          end
        end
        ID_VOLT: begin
          if (!state_i.seen_flags[SEEN_VLT]) begin
            s.volt_store           = apply_val;
            s.seen_flags[SEEN_VLT] = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result_o.frame_valid       = s.header_ok;
    result_o.frame_complete    = s.header_ok && (s.phase == PH_ID);
    result_o.packet_number     = s.packet_store;
    result_o.has_packet_number = s.seen_flags[SEEN_PKT];
    result_o.battery_percent   = s.battery_store;
    result_o.has_battery       = s.seen_flags[SEEN_BAT];
    result_o.temp_centideg     = s.temp_store;
    result_o.has_temp          = s.seen_flags[SEEN_TMP];
    result_o.humid_centipct    = s.humid_store;
    result_o.has_humid         = s.seen_flags[SEEN_HUM];
    result_o.volt_millivolts   = s.volt_store;
    result_o.has_volt          = s.seen_flags[SEEN_VLT];
  end

  // frame end returns to the header phase with cleared stores
  assign state_o = beat_i.last_byte ? '0 : s;

endmodule

[sv/sensor_advert_object_parser.sv]
// ----------------------------------------------------------------------------
// sensor_advert_object_parser
// Parses advertisement service-data objects and emits one summary per frame.
// ----------------------------------------------------------------------------
// the summary is registered in the cycle after the beat with last_byte
// throughput: one payload byte per cycle while byte_i.ready is high
// a byte is still taken while a summary waits, unless that summary is stalled
// reset: parse state clears to the header phase, the result register empties
// ----------------------------------------------------------------------------
module sensor_advert_object_parser import sap_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  sap_byte_if.sink     byte_i,
  sap_result_if.source result_o
);

  parse_state_t state_q;
  parse_state_t state_d;
  result_beat_t step_result;
  result_beat_t result_q;
  logic         out_valid_q;
  logic         in_fire;

  assign byte_i.ready     = !out_valid_q || result_o.ready;
  assign in_fire          = byte_i.valid && byte_i.ready;
  assign result_o.valid   = out_valid_q;
  assign result_o.payload = result_q;

  sap_step u_step (
    .state_i  (state_q),
    .beat_i   (byte_i.payload),
    .state_o  (state_d),
    .result_o (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire && byte_i.payload.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && byte_i.payload.last_byte) begin
      result_q <= step_result;
    end
  end

endmodule
